/* hdl/pip_pkg.sv */
// Shared types and constants for the point-in-polygon test block.
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int SLOT_W           = 6;
  localparam int VCOUNT_W         = 7;
  localparam int XCOUNT_W         = 7;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = VCOUNT_W'(3);

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_CLOSE,
    S_DRAIN,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic wr_vertex;
    logic start;
    logic rd_en;
    logic close;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic rd_last;
    logic pipe_busy;
  } dp_sts_t;

endpackage

/* hdl/pip_ctrl.sv */
// Controller: request handshakes and sequencing of the edge walk.
module pip_ctrl
  import pip_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    func_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (func_i == FUNC_QUERY)) begin
          state_d = sts_i.n_zero ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        if (sts_i.rd_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT:  state_d = S_CLOSE;
      S_CLOSE: state_d = S_DRAIN;
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_vertex = accept && (func_i == FUNC_WRITE);
    cmd_o.start     = accept && (func_i == FUNC_QUERY);
    case (state_q)
      S_READ:  cmd_o.rd_en    = 1'b1;
      S_CLOSE: cmd_o.close    = 1'b1;
      S_OUT:   cmd_o.load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/pip_dp.sv */
// Datapath: vertex store, edge straddle and cross-multiply test, crossing counter.
module pip_dp
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  output dp_sts_t                      sts_o,
  input  logic [SLOT_W-1:0]            vertex_index_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic                         cfg_we_i,
  input  logic [VCOUNT_W-1:0]          cfg_wdata_i,
  output logic                         inside_res_o,
  output logic [XCOUNT_W-1:0]          crossing_count_o
);

  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int VW    = 2 * COORD_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;

  logic [VW-1:0] mem [MAX_VERTICES];

  logic [VCOUNT_W-1:0]          vcount_q;
  logic [CNT_W-1:0]             n_q, n_d;
  logic [IDX_W-1:0]             rd_idx_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [VW-1:0]                rdata_q, prev_q, v0_q;
  logic                         rdv_q, rdfirst_q;
  logic                         wr_ok;

  logic                         edge_go;
  logic [VW-1:0]                ei, ej;
  logic signed [DW-1:0]         a_d, b_d, c_d, e_d;
  logic signed [DW-1:0]         a_q, b_q, c_q, e_q;
  logic                         up_d, down_d, up_q, down_q, dv_q;
  logic signed [PW-1:0]         p1_d, p2_d, p1_q, p2_q;
  logic                         up2_q, down2_q, mv_q, hit;
  logic [XCOUNT_W-1:0]          count_q, res_count_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RST;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (int'(vcount_q) > MAX_VERTICES) begin
      n_d = CNT_W'(MAX_VERTICES);
    end else begin
      n_d = CNT_W'(vcount_q);
    end
  end

  assign wr_ok = cmd_i.wr_vertex && (int'(vertex_index_i) < MAX_VERTICES);

  // vertex store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[IDX_W'(vertex_index_i)] <= {coord_y_i, coord_x_i};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
      n_q  <= n_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      rdv_q     <= 1'b0;
      rdfirst_q <= 1'b0;
    end else begin
      rdv_q <= cmd_i.rd_en;
      if (cmd_i.start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_en) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
      if (cmd_i.rd_en) begin
        rdfirst_q <= (rd_idx_q == '0);
      end
    end
  end

  // edge pair selection: consecutive vertices, or last back to first
  always_comb begin
    edge_go = cmd_i.close || (rdv_q && !rdfirst_q);
    ei      = prev_q;
    ej      = cmd_i.close ? v0_q : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      prev_q <= rdata_q;
      if (rdfirst_q) begin
        v0_q <= rdata_q;
      end
    end
  end

  always_comb begin
    a_d    = DW'($signed(ei[COORD_BITS-1:0])) - DW'(px_q);
    b_d    = DW'($signed(ej[COORD_BITS-1:0])) - DW'(px_q);
    c_d    = DW'($signed(ei[VW-1:COORD_BITS])) - DW'(py_q);
    e_d    = DW'($signed(ej[VW-1:COORD_BITS])) - DW'(py_q);
    up_d   = c_d[DW-1] && !e_d[DW-1];
    down_d = e_d[DW-1] && !c_d[DW-1];
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    e_q    <= e_d;
    up_q   <= up_d;
    down_q <= down_d;
  end

  assign p1_d = a_q * e_q;
  assign p2_d = c_q * b_q;

  always_ff @(posedge clk_i) begin
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    up2_q   <= up_q;
    down2_q <= down_q;
  end

  assign hit = (up2_q && (p1_q <= p2_q)) || (down2_q && (p1_q >= p2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q    <= 1'b0;
      mv_q    <= 1'b0;
      count_q <= '0;
    end else begin
      dv_q <= edge_go;
      mv_q <= dv_q;
      if (cmd_i.start) begin
        count_q <= '0;
      end else if (mv_q && hit) begin
        count_q <= count_q + XCOUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_count_q <= count_q;
    end
  end

  assign inside_res_o     = res_count_q[0];
  assign crossing_count_o = res_count_q;

  assign sts_o.n_zero    = (vcount_q == '0);
  assign sts_o.rd_last   = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == n_q);
  assign sts_o.pipe_busy = rdv_q | dv_q | mv_q;

endmodule

/* hdl/point_in_polygon_test.sv */
// Top level of the ray-casting point-in-polygon test.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, func, vertex_index, x, y  | request in
//   out     | out_valid_o/out_ready_i, inside_res, crossing_ct | result out
//   cfg     | cfg_we_i, cfg_wdata_i (vertex_count)             | write only
//
// A query walks n stored vertices (n = vertex_count, capped at MAX_VERTICES), none when
// n is zero; the single read port of the vertex store, one vertex a cycle, reads them in
// turn, and the result is loaded into the output register once the pipeline has drained.
// Reset clears control state and sets vertex_count to 3; the store is not cleared.
// A finished result waits in the output register while the next request is taken;
// a later query result holds until that register is free.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [SLOT_W-1:0]            vertex_index_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o,
  output logic [XCOUNT_W-1:0]          crossing_count_o,
  input  logic                         cfg_we_i,
  input  logic [VCOUNT_W-1:0]          cfg_wdata_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pip_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .vertex_index_i   (vertex_index_i),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .inside_res_o     (inside_res_o),
    .crossing_count_o (crossing_count_o)
  );

endmodule

/* sim/point_in_polygon_test_tb.sv */
// Self-checking testbench for the ray-casting point-in-polygon block.
`timescale 1ns / 1ps

module point_in_polygon_test_tb
  import pip_pkg::*;
();

  typedef struct packed {
    logic                in_poly;
    logic [XCOUNT_W-1:0] crossings;
  } verdict_t;

  class crossing_scoreboard;
    longint      vtx_x[MAX_VERTICES_DEF];
    longint      vtx_y[MAX_VERTICES_DEF];
    int unsigned vertex_count;
    verdict_t    pending[$];
    int          errors;
    int          checked;

    function new();
      vertex_count = VCOUNT_RST;
      errors       = 0;
      checked      = 0;
    endfunction

    function void set_vertex_count(logic [VCOUNT_W-1:0] value);
      vertex_count = value;
    endfunction

    // crossing number of the stored polygon for point (px, py), exact cross-multiply form
    function verdict_t count_crossings(longint px, longint py);
      verdict_t    v;
      int unsigned n, j, hits;
      longint      a, b, c, e;
      bit          up, down;
      n    = (vertex_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : vertex_count;
      hits = 0;
      for (int unsigned i = 0; i < n; i++) begin
        j    = (i + 1 == n) ? 0 : i + 1;
        a    = vtx_x[i] - px;
        b    = vtx_x[j] - px;
        c    = vtx_y[i] - py;
        e    = vtx_y[j] - py;
        up   = (c < 0) && (e >= 0);
        down = (e < 0) && (c >= 0);
        if ((up && a * e <= c * b) || (down && a * e >= c * b)) hits++;
      end
      v.crossings = XCOUNT_W'(hits);
      v.in_poly   = hits[0];
      return v;
    endfunction

    function void note_request(func_e f, logic [SLOT_W-1:0] slot,
                               logic signed [COORD_BITS_DEF-1:0] x,
                               logic signed [COORD_BITS_DEF-1:0] y);
      if (f == FUNC_WRITE) begin
        vtx_x[slot] = x;
        vtx_y[slot] = y;
      end else begin
        pending.push_back(count_crossings(longint'(x), longint'(y)));
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_result(logic is_in, logic [XCOUNT_W-1:0] crossings);
      verdict_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result inside=%0b crossings=%0d", is_in, crossings));
        return;
      end
      want = pending.pop_front();
      if (is_in !== want.in_poly)
        report($sformatf("result %0d inside_res got %0b want %0b", checked, is_in,
                         want.in_poly));
      if (crossings !== want.crossings)
        report($sformatf("result %0d crossing_count got %0d want %0d", checked, crossings,
                         want.crossings));
    endtask
  endclass

  localparam int CLK_HALF      = 4;
  localparam int SETTLE_CYCLES = MAX_VERTICES_DEF + 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int DIRECTED      = 23;
  localparam int RANDOM_ITEMS  = 950;

  typedef enum {SPAN_TINY, SPAN_MID, SPAN_FULL} span_e;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

  logic                             clk_i     = 1'b0;
  logic                             rst_ni    = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready_o;
  logic                             in_func   = FUNC_WRITE;
  logic [SLOT_W-1:0]                in_slot   = '0;
  logic signed [COORD_BITS_DEF-1:0] in_x      = '0;
  logic signed [COORD_BITS_DEF-1:0] in_y      = '0;
  logic                             out_valid_o;
  logic                             out_ready = 1'b0;
  logic                             inside_res_o;
  logic [XCOUNT_W-1:0]              crossing_count_o;
  logic                             cfg_we    = 1'b0;
  logic [VCOUNT_W-1:0]              cfg_wdata = '0;

  crossing_scoreboard sb = new();

  int poly_x[MAX_VERTICES_DEF];
  int poly_y[MAX_VERTICES_DEF];
  int burst_left  = 0;
  int n_writes    = 0;
  int n_queries   = 0;
  int n_settings  = 0;
  int idle_cycles = 0;

  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_tick      = 0;
  int       rx_hold_left = 0;

  point_in_polygon_test dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .func_i           (in_func),
    .vertex_index_i   (in_slot),
    .coord_x_i        (in_x),
    .coord_y_i        (in_y),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .inside_res_o     (inside_res_o),
    .crossing_count_o (crossing_count_o),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_ready = 1'b1;
      RX_COIN:   out_ready = 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready = (rx_tick % 4 == 0);
      default: begin
        if (rx_hold_left > 0) begin
          out_ready = 1'b0;
          rx_hold_left--;
        end else begin
          out_ready    = 1'b1;
          rx_hold_left = $urandom_range(0, 40);
        end
      end
    endcase
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) sb.check_result(inside_res_o, crossing_count_o);
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("point_in_polygon_test verification failed");
      $finish;
    end
  end

  task automatic send_request(func_e f, int slot, int x, int y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_func  = f;
    in_slot  = SLOT_W'(slot);
    in_x     = COORD_BITS_DEF'(x);
    in_y     = COORD_BITS_DEF'(y);
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(f, in_slot, in_x, in_y);
    if (f == FUNC_WRITE) begin
      poly_x[in_slot] = int'(in_x);
      poly_y[in_slot] = int'(in_y);
      n_writes++;
    end else begin
      n_queries++;
    end
    @(negedge clk_i);
  endtask

  // sender holds off until every result is back and the walk has drained
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(int value);
    cfg_wdata = VCOUNT_W'(value);
    cfg_we    = 1'b1;
    @(negedge clk_i);
    cfg_we = 1'b0;
    sb.set_vertex_count(VCOUNT_W'(value));
    n_settings++;
  endtask

  function automatic int pick_coord(span_e span);
    case (span)
      SPAN_TINY: return int'($urandom_range(0, 16)) - 8;
      SPAN_MID:  return int'($urandom_range(0, 4000)) - 2000;
      default:   return int'($signed(16'($urandom)));
    endcase
  endfunction

  // query points biased towards vertex heights and edges, where ties live
  task automatic query_near(int n, span_e span);
    int k, j, px, py;
    px = pick_coord(span);
    py = pick_coord(span);
    if (n > 0) begin
      k = $urandom_range(0, n - 1);
      j = (k + 1 == n) ? 0 : k + 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          px = poly_x[k] + int'($urandom_range(0, 2)) - 1;
          py = poly_y[j] + int'($urandom_range(0, 2)) - 1;
        end
        4, 5: begin
          px = (poly_x[k] + poly_x[j]) >>> 1;
          py = (poly_y[k] + poly_y[j]) >>> 1;
        end
        6:       py = poly_y[k];
        9:       px = pick_coord(SPAN_FULL);
        default: ;
      endcase
    end
    send_request(FUNC_QUERY, $urandom_range(0, 63), px, py);
  endtask

  initial begin
    int    schedule[$] = '{64, 127, 0, 1, 2, 65, 3};
    int    phase, cnt, n;
    span_e span;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset vertex count, extreme triangle with a horizontal edge
    send_request(FUNC_WRITE, 63, 32767, -32768);
    send_request(FUNC_WRITE, 0, -32768, -32768);
    send_request(FUNC_WRITE, 1, 32767, -32768);
    send_request(FUNC_WRITE, 2, 0, 32767);
    send_request(FUNC_QUERY, 63, 0, 0);
    send_request(FUNC_QUERY, 0, -32768, -32768);
    send_request(FUNC_QUERY, 63, 32767, -32768);
    send_request(FUNC_QUERY, 0, 0, 32767);
    send_request(FUNC_QUERY, 63, 0, -32768);
    send_request(FUNC_QUERY, 0, 32767, 32767);
    send_request(FUNC_QUERY, 63, -32768, 32767);
    send_request(FUNC_QUERY, 0, -1, -1);
    // small triangle: points on edges, on vertices, on the horizontal edge
    send_request(FUNC_WRITE, 0, 0, 0);
    send_request(FUNC_WRITE, 1, 32, 64);
    send_request(FUNC_WRITE, 2, 64, 0);
    send_request(FUNC_QUERY, 0, 32, 32);
    send_request(FUNC_QUERY, 0, 16, 32);
    send_request(FUNC_QUERY, 0, 48, 32);
    send_request(FUNC_QUERY, 0, 32, 0);
    send_request(FUNC_QUERY, 0, 0, 0);
    send_request(FUNC_QUERY, 0, 64, 0);
    send_request(FUNC_QUERY, 0, 32, 64);
    send_request(FUNC_QUERY, 0, -5, 32);

    // random phases; the first one loads all 64 slots
    phase = 0;
    while (n_writes + n_queries < DIRECTED + RANDOM_ITEMS) begin
      if (phase < schedule.size()) cnt = schedule[phase];
      else if ($urandom_range(0, 19) < 14) cnt = $urandom_range(3, 10);
      else if ($urandom_range(0, 1) == 0) cnt = $urandom_range(11, 64);
      else cnt = $urandom_range(0, 127);
      n = (cnt > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : cnt;
      wait_idle();
      write_vertex_count(cnt);
      repeat ($urandom_range(1, 3)) begin
        span = span_e'($urandom_range(0, 2));
        if (phase == 0 || $urandom_range(0, 4) != 0) begin
          for (int k = 0; k < n; k++)
            send_request(FUNC_WRITE, k, pick_coord(span), pick_coord(span));
          repeat ($urandom_range(4, 14)) query_near(n, span);
        end else begin
          repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 1) == 0)
              send_request(FUNC_WRITE, $urandom_range(0, 63), pick_coord(span),
                           pick_coord(span));
            else
              query_near(n, span);
          end
        end
      end
      phase++;
    end

    wait_idle();
    $display("run covered %0d vertex writes and %0d queries over %0d vertex_count settings",
             n_writes, n_queries, n_settings);
    $display("vertex counts from 0 to 127, %0d results checked, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("point_in_polygon_test verification clean");
    end else begin
      $display("point_in_polygon_test verification failed");
    end
    $finish;
  end

endmodule
